@@ src/digit_sum_divisible_range_count_unit_macros.svh @@
// assertion macros shared by the block
`ifndef DIGIT_SUM_DIVISIBLE_RANGE_COUNT_UNIT_MACROS_SVH
`define DIGIT_SUM_DIVISIBLE_RANGE_COUNT_UNIT_MACROS_SVH

// same-cycle implication
`define DSD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define DSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ src/dsdrc_pkg.sv @@
`timescale 1ns / 1ps
package dsdrc_pkg;

  localparam int MAX_MODULUS = 64;
  localparam int MAX_DIGITS  = 20;
  localparam int VAL_W       = 64;
  localparam int K_W         = 7;
  localparam int RES_W       = $clog2(MAX_MODULUS);
  localparam int DIG_W       = 4;
  localparam int BCD_W       = DIG_W * MAX_DIGITS;
  localparam int DCNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int CONV_W      = $clog2(VAL_W);
  localparam int PADDR_W     = 3;

  localparam logic [PADDR_W-1:0] ADDR_MODULUS = '0;

  typedef struct packed {
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [K_W-1:0]   k;
    logic             err;
  } item_t;

  function automatic logic [K_W-1:0] eff_modulus(input logic [K_W-1:0] m);
    logic [K_W-1:0] r;
    r = m;
    if (m == '0) begin
      r = K_W'(1);
    end else if (m > K_W'(MAX_MODULUS)) begin
      r = K_W'(MAX_MODULUS);
    end
    return r;
  endfunction

endpackage

@@ src/dsdrc_front.sv @@
`timescale 1ns / 1ps
module dsdrc_front import dsdrc_pkg::*; (
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [VAL_W-1:0] range_low,
  input  logic [VAL_W-1:0] range_high,
  input  logic [K_W-1:0]   modulus,
  input  logic             q_full,
  output logic             q_push,
  output item_t            q_item
);

  assign in_stall   = q_full;
  assign q_push     = in_valid && !q_full;
  assign q_item.lo  = range_low;
  assign q_item.hi  = range_high;
  assign q_item.k   = eff_modulus(modulus);
  assign q_item.err = range_low > range_high;

endmodule

@@ src/dsdrc_queue.sv @@
`timescale 1ns / 1ps
module dsdrc_queue import dsdrc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = count == 2'd2;
  assign q_valid = count != 2'd0;
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ src/dsdrc_back.sv @@
`timescale 1ns / 1ps
`include "digit_sum_divisible_range_count_unit_macros.svh"
module dsdrc_back import dsdrc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] match_count,
  output logic             range_error
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CONV, ST_RUN, ST_DRAIN, ST_TRED, ST_FRD, ST_FIN, ST_DONE
  } state_t;

  state_t              state;
  logic [VAL_W-1:0]    lo;
  logic [K_W-1:0]      k;
  logic                phase;
  logic [VAL_W-1:0]    bin;
  logic [BCD_W-1:0]    bcd;
  logic [CONV_W-1:0]   conv_cnt;
  logic [DCNT_W-1:0]   digit;
  logic [RES_W-1:0]    s;
  logic [DIG_W-1:0]    d;
  logic [RES_W-1:0]    idx;
  logic [RES_W-1:0]    tight;
  logic [K_W-1:0]      tsum;
  logic                bank;
  logic                first;
  logic [VAL_W-1:0]    acc;
  logic [VAL_W-1:0]    c_hi;
  logic                carry_hi;
  logic [VAL_W-1:0]    res_count;
  logic                res_err;
  logic                p_valid;
  logic                p_tight;
  logic                p_dfirst;
  logic                p_last;
  logic [RES_W-1:0]    p_s;

  logic [VAL_W-1:0] mem_a [MAX_MODULUS];
  logic [VAL_W-1:0] mem_b [MAX_MODULUS];
  logic [VAL_W-1:0] rd_a;
  logic [VAL_W-1:0] rd_b;

  logic [RES_W-1:0] k_m1;
  logic [DIG_W-1:0] b;
  logic [RES_W-1:0] raddr;
  logic [VAL_W-1:0] rdata;
  logic [VAL_W-1:0] acc_sum;
  logic             wr_en;
  logic [VAL_W-1:0] total;
  logic             carry;
  logic [VAL_W-1:0] diff;
  logic             out_free;

  function automatic logic [BCD_W-1:0] bcd_adj(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    r = v;
    for (int j = 0; j < MAX_DIGITS; j++) begin
      if (r[DIG_W*j +: DIG_W] >= DIG_W'(5)) begin
        r[DIG_W*j +: DIG_W] = r[DIG_W*j +: DIG_W] + DIG_W'(3);
      end
    end
    return r;
  endfunction

  assign k_m1     = RES_W'(k - K_W'(1));
  assign b        = bcd[BCD_W-1 -: DIG_W];
  assign raddr    = (state == ST_FRD) ? '0 : idx;
  assign rdata    = bank ? rd_b : rd_a;
  assign acc_sum  = (p_dfirst ? '0 : acc) + (first ? '0 : rdata) + VAL_W'(p_tight);
  assign wr_en    = p_valid && p_last;
  assign total    = rdata + VAL_W'(tight == '0);
  assign carry    = (tight == '0) && (rdata == '1);
  assign diff     = c_hi - total;
  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  // ping-pong residue count banks
  always_ff @(posedge clk) begin
    if (wr_en && !bank) begin
      mem_b[p_s] <= acc_sum;
    end
    if (wr_en && bank) begin
      mem_a[p_s] <= acc_sum;
    end
    rd_a <= mem_a[raddr];
    rd_b <= mem_b[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      p_valid   <= 1'b0;
      bank      <= 1'b0;
    end else begin
      p_valid  <= state == ST_RUN;
      p_tight  <= (d < b) && (idx == tight);
      p_dfirst <= d == '0;
      p_last   <= d == DIG_W'(9);
      p_s      <= s;
      if (p_valid) begin
        acc <= acc_sum;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            lo       <= q_item.lo;
            k        <= q_item.k;
            phase    <= 1'b0;
            bin      <= q_item.hi;
            bcd      <= '0;
            conv_cnt <= '0;
            if (q_item.err) begin
              res_count <= '0;
              res_err   <= 1'b1;
              state     <= ST_DONE;
            end else begin
              state <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          {bcd, bin} <= {bcd_adj(bcd), bin} << 1;
          conv_cnt   <= conv_cnt + CONV_W'(1);
          if (conv_cnt == '1) begin
            digit <= '0;
            s     <= '0;
            d     <= '0;
            idx   <= '0;
            tight <= '0;
            first <= 1'b1;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (d == DIG_W'(9)) begin
            d <= '0;
            if (s == k_m1) begin
              state <= ST_DRAIN;
            end else begin
              s   <= s + RES_W'(1);
              idx <= s + RES_W'(1);
            end
          end else begin
            d   <= d + DIG_W'(1);
            idx <= (idx == '0) ? k_m1 : idx - RES_W'(1);
          end
        end
        ST_DRAIN: begin
          tsum  <= K_W'(tight) + K_W'(b);
          bcd   <= bcd << DIG_W;
          digit <= digit + DCNT_W'(1);
          bank  <= !bank;
          first <= 1'b0;
          state <= ST_TRED;
        end
        ST_TRED: begin
          if (tsum >= k) begin
            tsum <= tsum - k;
          end else begin
            tight <= tsum[RES_W-1:0];
            s     <= '0;
            d     <= '0;
            idx   <= '0;
            state <= (digit == DCNT_W'(MAX_DIGITS)) ? ST_FRD : ST_RUN;
          end
        end
        ST_FRD: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          res_err <= 1'b0;
          if (!phase) begin
            c_hi     <= total;
            carry_hi <= carry;
            if (lo != '0) begin
              phase    <= 1'b1;
              bin      <= lo - VAL_W'(1);
              bcd      <= '0;
              conv_cnt <= '0;
              state    <= ST_CONV;
            end else begin
              res_count <= (carry && total == '0) ? '1 : total;
              state     <= ST_DONE;
            end
          end else begin
            res_count <= (carry_hi && diff == '0) ? '1 : diff;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            match_count <= res_count;
            range_error <= res_err;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `DSD_ASSERT_IMPL(a_err_zero, out_valid && range_error, match_count == '0)
  `DSD_ASSERT_IMPL(a_res_range, state == ST_RUN, (idx <= k_m1) && (tight <= k_m1))
  `DSD_ASSERT_NEXT(a_last_write, state == ST_RUN && d == DIG_W'(9) && s == k_m1, wr_en)

endmodule

@@ src/digit_sum_divisible_range_count_unit.sv @@
`timescale 1ns / 1ps
// counts the integers in range_low..range_high whose decimal digit sum is a
// multiple of the modulus register (register 0, 7 bits, reset 1; 0 acts as 1,
// above 64 acts as 64). write it only while the block is idle.
// input channel: in_valid / in_stall with range_low and range_high; an item
// is taken when in_valid is high and in_stall is low. a two-entry queue sits
// behind the input, so up to two items wait while one is being counted.
// output channel: out_valid / out_stall with match_count and range_error;
// one result per item, in order, held steady while out_stall is high. the
// counter keeps working on the next item while a result waits.
// each bound is handled as binary-to-bcd conversion, then for each of
// 20 digits a sweep of residue updates (one count memory read per
// cycle) and a reduction of the tight residue, then a final count read.
// an item counts range_high and, when range_low is nonzero, range_low-1; an
// item with range_low above range_high reports range_error, count zero.
// counts wrap mod 2^64 except the whole-range case, which saturates.
// reset (synchronous, active high) empties the queue, drops any result and
// sets the modulus to 1; the count memories need no clearing.
module digit_sum_divisible_range_count_unit import dsdrc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VAL_W-1:0]   range_low,
  input  logic [VAL_W-1:0]   range_high,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VAL_W-1:0]   match_count,
  output logic               range_error
);

  logic [K_W-1:0] modulus;
  logic           q_full;
  logic           q_push;
  item_t          push_item;
  logic           q_pop;
  logic           q_valid;
  item_t          q_item;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MODULUS) ? {{(32-K_W){1'b0}}, modulus} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= K_W'(1);
    end else if (psel && penable && pwrite && paddr == ADDR_MODULUS) begin
      modulus <= pwdata[K_W-1:0];
    end
  end

  dsdrc_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .range_low  (range_low),
    .range_high (range_high),
    .modulus    (modulus),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  dsdrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  dsdrc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .match_count (match_count),
    .range_error (range_error)
  );

endmodule
